### hdl/calc_lex_pkg.sv
// calc_lex_pkg: types and constants for the calculator expression lexer
// token kinds, per-character actions, character codes and index sizing
// no dependencies
package calc_lex_pkg;

   localparam int MAX_EXPR_LEN = 1024;
   localparam int INDEX_W      = $clog2(MAX_EXPR_LEN);

   localparam logic [7:0] DECIMAL_RESET = 8'h2e;

   localparam logic [7:0] CHAR_DIGIT_LO = 8'h30;
   localparam logic [7:0] CHAR_DIGIT_HI = 8'h39;
   localparam logic [7:0] CHAR_UPPER_LO = 8'h41;
   localparam logic [7:0] CHAR_UPPER_HI = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_LO = 8'h61;
   localparam logic [7:0] CHAR_LOWER_HI = 8'h7a;

   localparam logic [7:0] CHAR_LPAREN     = 8'h28;
   localparam logic [7:0] CHAR_RPAREN     = 8'h29;
   localparam logic [7:0] CHAR_UNDERSCORE = 8'h5f;
   localparam logic [7:0] CHAR_APOSTROPHE = 8'h27;
   localparam logic [7:0] CHAR_COMMA      = 8'h2c;
   localparam logic [7:0] CHAR_POINT      = 8'h2e;
   localparam logic [7:0] CHAR_PLUS       = 8'h2b;
   localparam logic [7:0] CHAR_STAR       = 8'h2a;
   localparam logic [7:0] CHAR_PERCENT    = 8'h25;
   localparam logic [7:0] CHAR_CARET      = 8'h5e;
   localparam logic [7:0] CHAR_LESS       = 8'h3c;
   localparam logic [7:0] CHAR_GREATER    = 8'h3e;
   localparam logic [7:0] CHAR_BANG       = 8'h21;
   localparam logic [7:0] CHAR_EQUALS     = 8'h3d;
   localparam logic [7:0] CHAR_MINUS      = 8'h2d;
   localparam logic [7:0] CHAR_SLASH      = 8'h2f;
   localparam logic [7:0] CHAR_SPACE      = 8'h20;

   localparam logic [10:0] LENGTH_MAX = 11'd2047;
   localparam logic [9:0]  SPACE_MAX  = 10'd1023;

   typedef enum logic [2:0] {
      K_PAR   = 3'd0,
      K_NUM   = 3'd1,
      K_NAME  = 3'd2,
      K_OPER  = 3'd3,
      K_COMMA = 3'd4
   } token_kind_type;

   typedef enum logic [1:0] {
      ACT_DROP    = 2'd0,
      ACT_APPEND  = 2'd1,
      ACT_START   = 2'd2,
      ACT_INVALID = 2'd3
   } action_type;

endpackage

### hdl/calc_expression_lexer.sv
// calc_expression_lexer: splits a calculator expression into tokens
// reported by their boundaries, one character per request
// depends on calc_lex_pkg
//
// usage
//   req channel: one character (req_char_in) per request, req_last set on
//   the final character of an expression; valid/ready handshake
//   rsp channel: one result per request, in order, valid/ready handshake
//   csr port: csr_write_enable/csr_write_data set the decimal substitute
//   byte; write only while no request is in flight
// timing
//   each request is classified against the token state in the cycle it is
//   accepted; its result is captured in the output register on acceptance
//   throughput is one request per cycle while rsp_ready stays high, set by
//   the token state register and the one-entry output register
// reset
//   synchronous, active high: token state cleared, decimal byte back to
//   '.', no result pending
// stall
//   while a result waits, req_ready follows rsp_ready, so a new request is
//   taken in the same cycle the pending result leaves
module calc_expression_lexer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [7:0]                    req_char_in,
   input  logic                          req_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output calc_lex_pkg::action_type      rsp_char_action,
   output logic [7:0]                    rsp_out_char,
   output calc_lex_pkg::token_kind_type  rsp_cur_kind,
   output logic                          rsp_token_done,
   output calc_lex_pkg::token_kind_type  rsp_done_type,
   output logic [9:0]                    rsp_done_pos,
   output logic [9:0]                    rsp_char_pos,
   output logic                          rsp_final_done,
   output calc_lex_pkg::token_kind_type  rsp_final_type,
   output logic [10:0]                   rsp_final_pos,
   input  logic                          csr_write_enable,
   input  logic [7:0]                    csr_write_data
);
   import calc_lex_pkg::*;

   localparam logic [INDEX_W-1:0] INDEX_MAX = INDEX_W'(MAX_EXPR_LEN - 1);

   // token state
   token_kind_type     kind_ff, kind_in;
   logic [7:0]         first_ff, first_in;
   logic [10:0]        length_ff, length_in;
   logic               in_func_ff, in_func_in;
   logic [9:0]         space_ff, space_in;
   logic [INDEX_W-1:0] index_ff, index_in;
   logic               failed_ff, failed_in;
   logic [7:0]         decimal_ff;

   // result register
   logic               rsp_valid_ff;
   action_type         action_ff, action_in;
   logic [7:0]         out_char_ff, out_char_in;
   token_kind_type     cur_kind_ff, cur_kind_in;
   logic               done_ff, done_in;
   token_kind_type     done_type_ff, done_type_in;
   logic [9:0]         done_pos_ff, done_pos_in;
   logic [9:0]         char_pos_ff, char_pos_in;
   logic               final_ff, final_in;
   token_kind_type     final_type_ff, final_type_in;
   logic [10:0]        final_pos_ff, final_pos_in;

   logic               req_accept;
   logic               do_start, do_append, bad;
   token_kind_type     start_kind;
   logic [7:0]         write_char;
   logic               digit, letter, lone_len;
   logic [31:0]        index_wide;
   logic [10:0]        index_low, done_diff;

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   assign index_wide = 32'(index_ff);
   assign index_low  = index_wide[10:0];

   assign digit  = (req_char_in >= CHAR_DIGIT_LO) && (req_char_in <= CHAR_DIGIT_HI);
   assign letter = ((req_char_in >= CHAR_UPPER_LO) && (req_char_in <= CHAR_UPPER_HI)) ||
                   ((req_char_in >= CHAR_LOWER_LO) && (req_char_in <= CHAR_LOWER_HI));
   assign lone_len  = (length_ff == 11'd1);
   assign done_diff = index_low - length_ff - {1'b0, space_ff};

   always_comb begin
      kind_in       = kind_ff;
      first_in      = first_ff;
      length_in     = length_ff;
      in_func_in    = in_func_ff;
      space_in      = space_ff;
      index_in      = index_ff;
      failed_in     = failed_ff;
      action_in     = ACT_DROP;
      out_char_in   = 8'd0;
      done_in       = 1'b0;
      done_type_in  = K_PAR;
      done_pos_in   = 10'd0;
      char_pos_in   = index_wide[9:0];
      final_in      = 1'b0;
      final_type_in = K_PAR;
      final_pos_in  = 11'd0;
      do_start      = 1'b0;
      do_append     = 1'b0;
      bad           = 1'b0;
      start_kind    = K_PAR;
      write_char    = req_char_in;

      if (!failed_ff) begin
         if (req_char_in == CHAR_LPAREN || req_char_in == CHAR_RPAREN) begin
            if (req_char_in == CHAR_LPAREN && kind_ff == K_NAME)
               in_func_in = 1'b1;
            else if (req_char_in == CHAR_RPAREN && in_func_ff)
               in_func_in = 1'b0;
            do_start   = 1'b1;
            start_kind = K_PAR;
         end else if (digit) begin
            if (kind_ff == K_NUM || kind_ff == K_NAME) begin
               do_append = 1'b1;
            end else begin
               do_start   = 1'b1;
               start_kind = K_NUM;
            end
         end else if (req_char_in == CHAR_UNDERSCORE) begin
            if (kind_ff == K_NAME)
               do_append = 1'b1;
            else if (kind_ff != K_NUM)
               bad = 1'b1;
         end else if (req_char_in == CHAR_APOSTROPHE) begin
            if (kind_ff != K_NUM)
               bad = 1'b1;
         end else if (req_char_in == CHAR_COMMA) begin
            if (in_func_ff) begin
               do_start   = 1'b1;
               start_kind = K_COMMA;
            end else if (kind_ff == K_NUM) begin
               do_append  = 1'b1;
               write_char = decimal_ff;
            end else begin
               bad = 1'b1;
            end
         end else if (req_char_in == CHAR_POINT) begin
            if (kind_ff == K_NAME) begin
               do_append = 1'b1;
            end else if (kind_ff == K_NUM) begin
               do_append  = 1'b1;
               write_char = decimal_ff;
            end else begin
               bad = 1'b1;
            end
         end else if (req_char_in == CHAR_PLUS || req_char_in == CHAR_STAR ||
                      req_char_in == CHAR_PERCENT || req_char_in == CHAR_CARET ||
                      req_char_in == CHAR_LESS || req_char_in == CHAR_GREATER ||
                      req_char_in == CHAR_BANG) begin
            do_start   = 1'b1;
            start_kind = K_OPER;
         end else if (req_char_in == CHAR_EQUALS) begin
            if (lone_len && (first_ff == CHAR_GREATER || first_ff == CHAR_LESS ||
                             first_ff == CHAR_EQUALS || first_ff == CHAR_BANG)) begin
               do_append = 1'b1;
            end else if (kind_ff == K_NAME) begin
               do_start   = 1'b1;
               start_kind = K_OPER;
            end else begin
               bad = 1'b1;
            end
         end else if (req_char_in == CHAR_MINUS) begin
            do_start = 1'b1;
            if (kind_ff == K_NAME || kind_ff == K_NUM ||
                (lone_len && first_ff == CHAR_RPAREN))
               start_kind = K_OPER;
            else
               start_kind = K_NUM;
         end else if (req_char_in == CHAR_SLASH) begin
            if (lone_len && first_ff == CHAR_SLASH) begin
               do_append = 1'b1;
            end else begin
               do_start   = 1'b1;
               start_kind = K_OPER;
            end
         end else if (letter) begin
            if (kind_ff == K_NAME) begin
               do_append = 1'b1;
            end else begin
               do_start   = 1'b1;
               start_kind = K_NAME;
            end
         end else if (req_char_in == CHAR_SPACE) begin
            if (space_ff < SPACE_MAX)
               space_in = space_ff + 10'd1;
         end else begin
            bad = 1'b1;
         end

         if (do_start) begin
            if (length_ff != 11'd0) begin
               done_in      = 1'b1;
               done_type_in = kind_ff;
               done_pos_in  = done_diff[9:0];
            end
            kind_in     = start_kind;
            first_in    = req_char_in;
            length_in   = 11'd1;
            action_in   = ACT_START;
            out_char_in = req_char_in;
         end else if (do_append) begin
            if (length_ff < LENGTH_MAX)
               length_in = length_ff + 11'd1;
            action_in   = ACT_APPEND;
            out_char_in = write_char;
         end

         if (bad) begin
            failed_in   = 1'b1;
            action_in   = ACT_INVALID;
            out_char_in = req_char_in;
         end else begin
            if (req_char_in != CHAR_SPACE)
               space_in = 10'd0;
            if (req_last && length_in != 11'd0) begin
               final_in      = 1'b1;
               final_type_in = kind_in;
               final_pos_in  = index_low + 11'd1 - length_in;
            end
         end
      end

      cur_kind_in = kind_in;

      // end of expression: back to the reset state
      if (req_last) begin
         kind_in    = K_PAR;
         first_in   = 8'd0;
         length_in  = 11'd0;
         in_func_in = 1'b0;
         space_in   = 10'd0;
         index_in   = '0;
         failed_in  = 1'b0;
      end else if (index_ff < INDEX_MAX) begin
         index_in = index_ff + INDEX_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         kind_ff      <= K_PAR;
         first_ff     <= 8'd0;
         length_ff    <= 11'd0;
         in_func_ff   <= 1'b0;
         space_ff     <= 10'd0;
         index_ff     <= '0;
         failed_ff    <= 1'b0;
         decimal_ff   <= DECIMAL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable)
            decimal_ff <= csr_write_data;
         if (req_accept) begin
            kind_ff    <= kind_in;
            first_ff   <= first_in;
            length_ff  <= length_in;
            in_func_ff <= in_func_in;
            space_ff   <= space_in;
            index_ff   <= index_in;
            failed_ff  <= failed_in;
         end
         if (req_accept)
            rsp_valid_ff <= 1'b1;
         else if (rsp_ready)
            rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         action_ff     <= action_in;
         out_char_ff   <= out_char_in;
         cur_kind_ff   <= cur_kind_in;
         done_ff       <= done_in;
         done_type_ff  <= done_type_in;
         done_pos_ff   <= done_pos_in;
         char_pos_ff   <= char_pos_in;
         final_ff      <= final_in;
         final_type_ff <= final_type_in;
         final_pos_ff  <= final_pos_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_char_action = action_ff;
   assign rsp_out_char    = out_char_ff;
   assign rsp_cur_kind    = cur_kind_ff;
   assign rsp_token_done  = done_ff;
   assign rsp_done_type   = done_type_ff;
   assign rsp_done_pos    = done_pos_ff;
   assign rsp_char_pos    = char_pos_ff;
   assign rsp_final_done  = final_ff;
   assign rsp_final_type  = final_type_ff;
   assign rsp_final_pos   = final_pos_ff;

   // a completed token is only reported by a character that starts one
   a_done_on_start: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && done_ff |-> action_ff == ACT_START)
      else $error("token completion without a new token");

   // the last character always returns the lexer to its reset state
   a_last_clears: assert property (@(posedge clock) disable iff (reset)
      req_accept && req_last |=> index_ff == '0 && !failed_ff && length_ff == 11'd0)
      else $error("state not cleared after last character");

   // after an error, characters are dropped until the end
   a_failed_drops: assert property (@(posedge clock) disable iff (reset)
      req_accept && failed_ff |=> action_ff == ACT_DROP && !done_ff && !final_ff)
      else $error("activity after error");

   // an invalid character always leaves the lexer failed unless it ends the expression
   a_invalid_sets_failed: assert property (@(posedge clock) disable iff (reset)
      req_accept && !req_last && action_in == ACT_INVALID |=> failed_ff)
      else $error("invalid character did not set the error flag");

endmodule
